// ----- rtl/lgf_pkg.sv -----
// Package for the largest free gap finder.
// Holds the beat structs, status codes, register indexes and state type.
// No dependencies.
package lgf_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE = 8'd1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_WINDOW = 3'd1,
        ST_OVERFLOW   = 3'd2,
        ST_NONE       = 3'd3,
        ST_TOO_MANY   = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_LOAD,
        S_CHECK,
        S_SCAN,
        S_STEP
    } t_state;

    // One input beat.
    typedef struct packed {
        logic [63:0] range_start;
        logic [63:0] range_length;
        logic        entry_present;
        logic        last_entry;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_status     status;
        logic [63:0] usable_base;
        logic [63:0] usable_size;
    } t_result;

    // A stored reservation, end exclusive, unclipped.
    typedef struct packed {
        logic [63:0] r_start;
        logic [63:0] r_end;
    } t_range;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic en;
    } t_scan_ctl;

    // Accumulated outcome of one scan over the stored ranges.
    typedef struct packed {
        logic        cov;
        logic        ahead;
        logic [63:0] ns;
        logic [63:0] ne;
    } t_scan_acc;

endpackage

// ----- rtl/lgf_cell.sv -----
// One cell of the reservation ring: holds a single range.
// On enable it takes the range offered by its neighbour. Uses lgf_pkg.
module lgf_cell
    import lgf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_range i_range,
    output t_range o_range
);

    t_range r_range;

    // Shift stage: take the neighbour's range when the ring moves.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_range <= i_range;
        end
    end

    assign o_range = r_range;

endmodule

// ----- rtl/lgf_scan.sv -----
// Scan unit: looks at one range per cycle while enabled, as the ring rotates past it.
// Keeps the furthest covering end and the nearest start ahead. Uses lgf_pkg.
module lgf_scan
    import lgf_pkg::*;
(
    input  logic        i_clk,
    input  t_scan_ctl   i_ctl,
    input  t_range      i_range,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_cur,
    output t_scan_acc   o_acc
);

    t_scan_acc   r_acc;
    t_scan_acc   n_acc;
    logic        skip;
    logic [63:0] s_clip;
    logic [63:0] e_clip;
    logic        covers;

    // Clip the range to the window and classify it against the cursor.
    always_comb begin
        skip   = (i_range.r_end <= i_lo) || (i_range.r_start >= i_hi);
        s_clip = (i_range.r_start < i_lo) ? i_lo : i_range.r_start;
        e_clip = (i_range.r_end > i_hi) ? i_hi : i_range.r_end;
        covers = (s_clip <= i_cur) && (i_cur < e_clip);
    end

    // Fold the range into the running result.
    always_comb begin
        n_acc = r_acc;
        if (!skip) begin
            if (covers) begin
                if (!r_acc.cov || (e_clip > r_acc.ne)) begin
                    n_acc.ne = e_clip;
                end
                n_acc.cov = 1'b1;
            end else if (!r_acc.cov && (s_clip > i_cur)
                         && (!r_acc.ahead || (s_clip < r_acc.ns))) begin
                n_acc.ns    = s_clip;
                n_acc.ahead = 1'b1;
            end
        end
    end

    // Accumulator register; cleared before each scan.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc.cov   <= 1'b0;
            r_acc.ahead <= 1'b0;
        end else if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    // Payload of the accumulator needs no clearing.
    assign o_acc = r_acc;

endmodule

// ----- rtl/largest_free_gap_finder.sv -----
// Largest free gap finder. Reserved ranges are loaded one beat per cycle while
// busy is low; the beat marked last_entry starts a walk over the RAM window and
// exactly one result beat follows, shown for one cycle with o_done high, which the
// receiver must take as it comes. The walk makes at most 2*MAX_RANGES+2 steps,
// each a full turn of the ring of MAX_RANGES cells past the single scan unit
// followed by a step state; on a bad window or a load error the result follows
// the window check and no walk is made.
// The configuration port is always ready; write it only while the block is idle.
// Depends on lgf_pkg, lgf_cell and lgf_scan.
module largest_free_gap_finder
    import lgf_pkg::*;
#(
    parameter int MAX_RANGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_done,
    output t_result              o_result
);

    localparam int CW        = $clog2(MAX_RANGES + 1);
    localparam int KW        = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int GUARD_LIM = 2 * MAX_RANGES + 2;
    localparam int GW        = $clog2(GUARD_LIM + 1);

    t_state      r_state;
    t_state      n_state;
    logic [63:0] r_mem_base;
    logic [63:0] r_mem_size;
    logic [CW-1:0] r_count;
    t_status     r_err;
    logic [63:0] r_cur;
    logic [63:0] r_hi;
    logic [63:0] r_best_base;
    logic [63:0] r_best_size;
    logic [KW-1:0] r_k;
    logic [GW-1:0] r_guard;
    logic        r_done;
    t_result     r_result;

    logic        accept;
    logic        ring_en;
    logic        load_shift;
    t_scan_ctl   scan_ctl;
    t_scan_acc   acc;
    t_range      cell_q [MAX_RANGES];
    t_range      new_range;
    logic [64:0] load_sum;
    logic        load_ovf;
    logic        load_nz;
    logic        count_full;
    logic [64:0] win_sum;
    logic        win_bad;
    logic        k_last;
    logic        k_valid;
    logic [63:0] gap_end;
    logic [63:0] free_len;
    logic        gap_better;
    logic [63:0] step_base;
    logic [63:0] step_size;
    logic        found;
    logic [63:0] new_cur;
    logic [GW-1:0] n_guard;
    logic        walk_end;

    // Load-side checks on the incoming beat.
    always_comb begin
        accept     = start && !busy;
        load_sum   = {1'b0, i_item.range_start} + {1'b0, i_item.range_length};
        load_ovf   = load_sum[64];
        load_nz    = i_item.entry_present && (i_item.range_length != 64'd0);
        count_full = (r_count >= CW'(MAX_RANGES));
        load_shift = accept && load_nz && !load_ovf && !count_full;
        new_range.r_start = i_item.range_start;
        new_range.r_end   = load_sum[63:0];
    end

    // Window check and scan position.
    always_comb begin
        win_sum = {1'b0, r_mem_base} + {1'b0, r_mem_size};
        win_bad = (r_mem_size == 64'd0) || win_sum[64];
        k_last  = (r_k == KW'(MAX_RANGES - 1));
        k_valid = ({1'b0, CW'(r_k)} >= ({1'b0, CW'(MAX_RANGES)} - {1'b0, r_count}));
    end

    // Step decision from the finished scan.
    always_comb begin
        gap_end    = acc.ahead ? acc.ns : r_hi;
        free_len   = gap_end - r_cur;
        gap_better = !acc.cov && (free_len > r_best_size);
        step_base  = gap_better ? r_cur : r_best_base;
        step_size  = gap_better ? free_len : r_best_size;
        found      = acc.cov || acc.ahead;
        new_cur    = acc.cov ? acc.ne : acc.ns;
        n_guard    = r_guard + GW'(1);
        walk_end   = !found || !(n_guard < GW'(GUARD_LIM)) || !(new_cur < r_hi);
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (accept && i_item.last_entry) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (win_bad || (r_err != ST_OK)) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (k_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (walk_end) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Output and control decode.
    always_comb begin
        busy           = 1'b1;
        ring_en        = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.en    = 1'b0;
        case (r_state)
            S_LOAD: begin
                busy    = 1'b0;
                ring_en = load_shift;
            end
            S_CHECK: begin
                scan_ctl.clear = 1'b1;
            end
            S_SCAN: begin
                ring_en     = 1'b1;
                scan_ctl.en = k_valid;
            end
            S_STEP: begin
                scan_ctl.clear = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Ring of cells: loading pushes into cell zero, scanning turns the ring.
    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
        t_range cell_d;
        if (i == 0) begin : g_head
            assign cell_d = (r_state == S_LOAD) ? new_range : cell_q[MAX_RANGES-1];
        end else begin : g_body
            assign cell_d = cell_q[i-1];
        end
        lgf_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (ring_en),
            .i_range (cell_d),
            .o_range (cell_q[i])
        );
    end

    // The scan unit watches the cell leaving the end of the ring.
    lgf_scan u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_range (cell_q[MAX_RANGES-1]),
        .i_lo    (r_mem_base),
        .i_hi    (r_hi),
        .i_cur   (r_cur),
        .o_acc   (acc)
    );

    // State, configuration, load bookkeeping and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_mem_base <= 64'd0;
            r_mem_size <= 64'd0;
            r_count    <= '0;
            r_err      <= ST_OK;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MEM_BASE: r_mem_base <= i_cfg_data;
                    REG_MEM_SIZE: r_mem_size <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    if (accept && load_nz) begin
                        if (load_ovf) begin
                            if (r_err == ST_OK) begin
                                r_err <= ST_OVERFLOW;
                            end
                        end else if (count_full) begin
                            if (r_err == ST_OK) begin
                                r_err <= ST_TOO_MANY;
                            end
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_CHECK: begin
                    if (win_bad || (r_err != ST_OK)) begin
                        r_done  <= 1'b1;
                        r_count <= '0;
                        r_err   <= ST_OK;
                    end
                end
                S_STEP: begin
                    if (walk_end) begin
                        r_done  <= 1'b1;
                        r_count <= '0;
                        r_err   <= ST_OK;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Walk datapath: cursor, best gap, ring position and step guard.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CHECK: begin
                r_cur       <= r_mem_base;
                r_hi        <= win_sum[63:0];
                r_best_base <= 64'd0;
                r_best_size <= 64'd0;
                r_k         <= '0;
                r_guard     <= '0;
                r_result.usable_base <= 64'd0;
                r_result.usable_size <= 64'd0;
                r_result.status      <= win_bad ? ST_BAD_WINDOW : r_err;
            end
            S_SCAN: begin
                r_k <= k_last ? '0 : r_k + KW'(1);
            end
            S_STEP: begin
                r_best_base <= step_base;
                r_best_size <= step_size;
                r_guard     <= n_guard;
                if (found) begin
                    r_cur <= new_cur;
                end
                if (step_size == 64'd0) begin
                    r_result.status      <= ST_NONE;
                    r_result.usable_base <= 64'd0;
                    r_result.usable_size <= 64'd0;
                end else begin
                    r_result.status      <= ST_OK;
                    r_result.usable_base <= step_base;
                    r_result.usable_size <= step_size;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A result only follows the window check or the last walk step.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_CHECK) || ($past(r_state) == S_STEP))
        else $error("result strobe without a finishing state");

    // A failed status carries no gap, and a good one carries a nonempty gap.
    a_res_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.status == ST_OK) && (o_result.usable_size != 64'd0))
                || ((o_result.status != ST_OK) && (o_result.usable_size == 64'd0)
                    && (o_result.usable_base == 64'd0)))
        else $error("result fields disagree with status");

    // The stored count never passes the number of cells.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("range count beyond ring size");

    // While scanning the cursor stays inside the window.
    a_cur_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cur < r_hi) && (r_cur >= r_mem_base))
        else $error("walk cursor outside the window");

    // The count and error are back to zero once a result has gone out.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_count == '0) && (r_err == ST_OK))
        else $error("load state not cleared after a result");

endmodule

// ----- tb/tb_largest_free_gap_finder.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the largest free gap finder: directed and random range lists.
// A built-in predictor computes each gap report and a checker compares it with o_result.
// Depends on lgf_pkg and largest_free_gap_finder.
module tb_largest_free_gap_finder;
    import lgf_pkg::*;

    localparam int MAX_RANGES = 16;
    localparam logic [63:0] ALL_ONES = '1;
    localparam int ITEM_TARGET = 1150;
    localparam int IDLE_SETTLE = 4;
    localparam int END_SETTLE = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_done;
    t_result              o_result;

    // Predictor copy of the window registers and the loaded reservations.
    logic [63:0] win_base = '0;
    logic [63:0] win_size = '0;
    logic [63:0] rsv_start [MAX_RANGES];
    logic [63:0] rsv_end [MAX_RANGES];
    int          rsv_count = 0;
    t_status     load_status = ST_OK;

    // Gap reports still owed by the block, oldest first.
    t_result gap_reports_due [$];

    int  mismatch_count = 0;
    int  items_counted = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  stall_cycles = 0;

    largest_free_gap_finder #(
        .MAX_RANGES(MAX_RANGES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_item range_beat(input logic [63:0] base, input logic [63:0] len,
                                         input bit present, input bit last);
        t_item it;
        it.range_start   = base;
        it.range_length  = len;
        it.entry_present = present;
        it.last_entry    = last;
        return it;
    endfunction

    // Walk the window over the stored reservations and keep the widest free gap.
    function automatic t_status walk_window(output logic [63:0] gap_base,
                                            output logic [63:0] free_len);
        logic [63:0] top, cur, ns, ne, s, e, stop;
        bit          cov, done;
        int          steps, i;
        gap_base = '0;
        free_len = '0;
        if (win_size == 64'd0 || win_base > ALL_ONES - win_size) return ST_BAD_WINDOW;
        if (load_status != ST_OK) return load_status;
        top  = win_base + win_size;
        cur  = win_base;
        done = 1'b0;
        for (steps = 0; steps < 2 * MAX_RANGES + 2 && cur < top && !done; steps++) begin
            // Find the covering reservation reaching furthest, else the nearest one ahead.
            cov = 1'b0;
            ns  = top;
            ne  = top;
            for (i = 0; i < rsv_count; i++) begin
                s = rsv_start[i];
                e = rsv_end[i];
                if (e > win_base && s < top) begin
                    if (s < win_base) s = win_base;
                    if (e > top) e = top;
                    if (s <= cur && cur < e) begin
                        if (!cov || e > ne) begin
                            ns = s;
                            ne = e;
                        end
                        cov = 1'b1;
                    end else if (!cov && s > cur && s < ns) begin
                        ns = s;
                    end
                end
            end
            if (!cov && ns >= top) begin
                // Nothing further ahead: the rest of the window is free.
                if (top - cur > free_len) begin
                    gap_base = cur;
                    free_len = top - cur;
                end
                done = 1'b1;
            end else begin
                stop = cov ? ne : ns;
                if (ns > cur && ns - cur > free_len) begin
                    gap_base = cur;
                    free_len = ns - cur;
                end
                cur = (stop > cur) ? stop : ns;
            end
        end
        if (free_len == 64'd0) return ST_NONE;
        return ST_OK;
    endfunction

    // Absorb one accepted beat; returns 1 when it produces a gap report.
    function automatic bit predict_gap_report(input t_item it, output t_result rep);
        logic [63:0] gb, gs;
        rep = '0;
        if (it.entry_present && it.range_length != 64'd0) begin
            if (it.range_start > ALL_ONES - it.range_length) begin
                if (load_status == ST_OK) load_status = ST_OVERFLOW;
            end else if (rsv_count >= MAX_RANGES) begin
                if (load_status == ST_OK) load_status = ST_TOO_MANY;
            end else begin
                rsv_start[rsv_count] = it.range_start;
                rsv_end[rsv_count]   = it.range_start + it.range_length;
                rsv_count++;
            end
        end
        if (!it.last_entry) return 1'b0;
        rep.status      = walk_window(gb, gs);
        rep.usable_base = gb;
        rep.usable_size = gs;
        rsv_count       = 0;
        load_status     = ST_OK;
        return 1'b1;
    endfunction

    // Send one beat, opening a random gap at the start of some bursts while gaps are on.
    task automatic send_item(input t_item it);
        t_result rep;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (predict_gap_report(it, rep)) gap_reports_due.push_back(rep);
        items_counted++;
    endtask

    // Stop sending and let every owed report arrive, then wait out the settle time.
    task automatic wait_idle(input int settle);
        start <= 1'b0;
        while (gap_reports_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write both window registers in consecutive beats.
    task automatic write_window(input logic [63:0] base, input logic [63:0] size);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_MEM_BASE;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_base = base;
        i_cfg_index <= REG_MEM_SIZE;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_size = size;
        i_cfg_valid <= 1'b0;
    endtask

    // Random beat, mostly a range near the window, the rest noise and odd cases.
    function automatic t_item random_range_item(input bit last);
        t_item       it;
        logic [63:0] span;
        int          pick;
        span = (win_size == 64'd0 || win_size > 64'h10_0000) ? 64'h10_0000 : win_size;
        pick = $urandom_range(0, 99);
        it = range_beat(win_base - span / 4 + rand64() % (span + span / 2),
                        64'd1 + rand64() % (span / 3 + 1), 1'b1, last);
        if (pick < 70) begin
            // Keep the range near the window.
        end else if (pick < 78) begin
            it.range_start  = rand64();
            it.range_length = rand64();
        end else if (pick < 84) begin
            it.range_length = '0;
        end else if (pick < 90) begin
            it.entry_present = 1'b0;
            it.range_start   = rand64();
            it.range_length  = rand64();
        end else if (pick < 93) begin
            it.range_start  = ALL_ONES - {32'd0, $urandom};
            it.range_length = (ALL_ONES - it.range_start) + 64'd1
                              + 64'($urandom_range(0, 1000));
        end else if (pick < 96) begin
            it.range_start = win_base;
        end else begin
            it.range_start = win_base + win_size - it.range_length;
        end
        return it;
    endfunction

    task automatic send_random_list();
        int n, k;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
        for (k = 0; k <= n; k++) send_item(random_range_item(k == n));
    endtask

    // Window registers at their reset values give a bad window.
    task automatic test_reset_window();
        send_item(range_beat(ALL_ONES, ALL_ONES, 1'b0, 1'b1));
        wait_idle(IDLE_SETTLE);
    endtask

    // Gaps, ignored and outside ranges, ties and a fully reserved window.
    task automatic test_directed_gaps();
        write_window(64'h1000, 64'h1000);
        send_item(range_beat(64'h0, 64'h0, 1'b0, 1'b1));
        send_item(range_beat(64'h1200, 64'h100, 1'b1, 1'b0));
        send_item(range_beat(64'h1800, 64'h0, 1'b1, 1'b0));
        send_item(range_beat(64'h0, 64'h10, 1'b1, 1'b0));
        send_item(range_beat(64'h1f00, 64'h1000, 1'b1, 1'b0));
        send_item(range_beat(64'h1000, 64'h80, 1'b1, 1'b1));
        send_item(range_beat(64'h1400, 64'h800, 1'b1, 1'b1));
        send_item(range_beat(64'h0, 64'h10000, 1'b1, 1'b1));
        wait_idle(IDLE_SETTLE);
    endtask

    // Range overflow, then one range more than the store holds.
    task automatic test_load_errors();
        int i;
        send_item(range_beat(ALL_ONES, 64'd1, 1'b1, 1'b0));
        send_item(range_beat(64'h0, ALL_ONES, 1'b1, 1'b1));
        send_item(range_beat(64'h0, ALL_ONES, 1'b1, 1'b0));
        for (i = 1; i <= MAX_RANGES; i++)
            send_item(range_beat(64'h3000 + 64'h10 * i, 64'd8, 1'b1, i == MAX_RANGES));
        wait_idle(IDLE_SETTLE);
    endtask

    // Random windows, extremes among them, each followed by a few random lists.
    task automatic test_random_lists();
        logic [63:0] base, size;
        while (items_counted < ITEM_TARGET) begin
            size = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(16, 64))
                                               : 64'($urandom_range(65, 65536));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: base = rand64();
                4, 5: base = {32'd0, $urandom};
                6: begin
                    base = '0;
                    size = ALL_ONES;
                end
                7: base = ALL_ONES - size;
                8: begin
                    base = rand64();
                    size = '0;
                end
                default: begin
                    base = rand64() | {1'b1, 63'd0};
                    size = rand64() | {1'b1, 63'd0};
                end
            endcase
            wait_idle(IDLE_SETTLE);
            write_window(base, size);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (4) send_random_list();
        end
    endtask

    // Compare each report beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (gap_reports_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected report status %0d base %h size %h", $realtime,
                             o_result.status, o_result.usable_base, o_result.usable_size);
            end else begin
                want = gap_reports_due.pop_front();
                if (o_result.status !== want.status ||
                    o_result.usable_base !== want.usable_base ||
                    o_result.usable_size !== want.usable_size) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: expected status %0d base %h size %h, got %0d %h %h",
                                 $realtime, want.status, want.usable_base, want.usable_size,
                                 o_result.status, o_result.usable_base, o_result.usable_size);
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("largest_free_gap_finder test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_window();
        test_directed_gaps();
        test_load_errors();
        test_random_lists();
        wait_idle(END_SETTLE);
        if (mismatch_count == 0 && gap_reports_due.size() == 0) begin
            $display("largest_free_gap_finder test passed");
        end else begin
            $display("largest_free_gap_finder test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lgf_pkg.sv
rtl/lgf_cell.sv
rtl/lgf_scan.sv
rtl/largest_free_gap_finder.sv
tb/tb_largest_free_gap_finder.sv
